// ===== src/dcza_pkg.sv =====
// dcza_pkg: types, constants and helpers shared by the depth-to-color z-buffer block
// used by dcza_axis_map and depth_to_color_zbuffer_align; depends on nothing
`timescale 1ns / 1ps

package dcza_pkg;

	// store geometry
	localparam int MAX_COLS  = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int MAX_DIM   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int MEM_DEPTH = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// field widths
	localparam int PIX_W   = 10;
	localparam int DEPTH_W = 16;
	localparam int CELL_W  = 14;
	localparam int CTR_W   = 16;   // Q12.4 principal points
	localparam int SC_W    = 20;   // Q4.16 focal ratio
	localparam int CW_W    = 11;   // color size
	localparam int CFG_W   = 20;
	localparam int CIDX_W  = 4;

	// coordinate width: holds a request position and any in-store mapped position
	localparam int CRD_W = (PIX_W > $clog2(MAX_DIM)) ? PIX_W : $clog2(MAX_DIM);
	// per-axis bound: min of color size and store size
	localparam int LIM_W = ($clog2(MAX_DIM + 1) > CW_W) ? $clog2(MAX_DIM + 1) : CW_W;

	// mapping arithmetic
	localparam int FRAC_SH = 20;                 // Q.4 times Q4.16
	localparam int CC_SH   = 16;                 // Q12.4 lifted to Q.20
	localparam int DIFF_W  = CTR_W + 1;
	localparam int PROD_W  = DIFF_W + SC_W + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int Q_W     = SUM_W - FRAC_SH + 1;

	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(10000);

	localparam logic [SC_W-1:0] SCALE_RST  = SC_W'(65536);
	localparam logic [CW_W-1:0] WIDTH_RST  = CW_W'(640);
	localparam logic [CW_W-1:0] HEIGHT_RST = CW_W'(480);

	typedef enum logic {
		REQ_PROJECT = 1'b0,
		REQ_READ    = 1'b1
	} req_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_DEPTH_CENTER_X = 4'd0,
		REG_DEPTH_CENTER_Y = 4'd1,
		REG_COLOR_CENTER_X = 4'd2,
		REG_COLOR_CENTER_Y = 4'd3,
		REG_SCALE_X        = 4'd4,
		REG_SCALE_Y        = 4'd5,
		REG_COLOR_WIDTH    = 4'd6,
		REG_COLOR_HEIGHT   = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		req_t               req_type;
		logic [PIX_W-1:0]   pix_col;
		logic [PIX_W-1:0]   pix_row;
		logic [DEPTH_W-1:0] depth_mm;
	} in_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_depth;
		logic [PIX_W-1:0]  cell_col;
		logic [PIX_W-1:0]  cell_row;
	} out_t;

	// per-axis mapping setup
	typedef struct packed {
		logic [CTR_W-1:0] depth_center;
		logic [SC_W-1:0]  scale;
		logic [CTR_W-1:0] color_center;
		logic [LIM_W-1:0] limit;
	} map_cfg_t;

	// per-axis mapping result
	typedef struct packed {
		logic [CRD_W-1:0] coord;
		logic             in_range;
	} map_res_t;

	// request side info carried along the pipeline
	typedef struct packed {
		req_t             req;
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic [CELL_W-1:0] depth;
		logic             depth_ok;
		logic             in_store;
	} side_t;

	// linear cell address, row major; valid only for in-store coordinates
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] c,
		input logic [CRD_W-1:0] r);
		logic [2*CRD_W:0] full;
		full = (2*CRD_W+1)'(r) * (2*CRD_W+1)'(MAX_COLS) + (2*CRD_W+1)'(c);
		return full[ADDR_W-1:0];
	endfunction

endpackage

// ===== src/dcza_axis_map.sv =====
// dcza_axis_map: one axis of the depth-to-color remap, three register stages
// depends on dcza_pkg
`timescale 1ns / 1ps

module dcza_axis_map (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dcza_pkg::PIX_W-1:0] pos,
	input  dcza_pkg::map_cfg_t        cfg,
	output dcza_pkg::map_res_t        res
);
	import dcza_pkg::*;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     neg;
	logic [SUM_W-1:0]         mag;
	logic [SUM_W-1:0]         rnd;
	logic [Q_W-1:0]           q;
	map_res_t                 res_s4;

	// position in Q.4 minus depth center, times the focal ratio
	always_comb begin
		diff = $signed(DIFF_W'({pos, 4'b0000})) - $signed(DIFF_W'(cfg.depth_center));
		prod = PROD_W'(diff) * PROD_W'($signed({1'b0, cfg.scale}));
	end

	// add the color center in Q.20
	assign sum = SUM_W'(prod_s2) + $signed(SUM_W'({cfg.color_center, CC_SH'(0)}));

	// round half away from zero on the magnitude
	always_comb begin
		neg = sum_s3[SUM_W-1];
		mag = neg ? SUM_W'(-sum_s3) : SUM_W'(sum_s3);
		rnd = mag + (SUM_W'(1) << (FRAC_SH - 1));
		q   = Q_W'(rnd >> FRAC_SH);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2         <= prod;
			sum_s3          <= sum;
			// a small negative that rounds to zero stays at zero
			res_s4.in_range <= (!neg || q == '0) && (q < Q_W'(cfg.limit));
			res_s4.coord    <= q[CRD_W-1:0];
		end
	end

	assign res = res_s4;

endmodule

// ===== src/depth_to_color_zbuffer_align.sv =====
// depth_to_color_zbuffer_align: top level, depth pixel registration into a nearest-depth z-buffer
// depends on dcza_pkg and dcza_axis_map
`timescale 1ns / 1ps

// A project request carries one depth pixel (column, row, millimetre depth).
// Depths of zero or above 10000 are dropped; otherwise the position is remapped
// per axis as round((pos - depth_center) * scale + color_center), halves away
// from zero, and if it lands inside both the color size and the 1024 x 1024
// store the cell keeps the smaller of its nonzero depth and the new one. A read
// request returns one cell (0 means empty) with its column and row and clears
// it. The block takes one request per clock; between the input and the output
// register lie the input register, three stages of mapping arithmetic per axis,
// the store read, then the compare and write back, with the write forwarded to
// a request one behind at the same cell. Apart from the clearing sweep, the input
// stalls only while a read result at the last stage is blocked by a stalled
// output register. After reset the store is swept to zero at one cell a clock,
// during which in_stall stays high; configuration writes are taken at any time
// but must only change while no request is in flight.

module depth_to_color_zbuffer_align (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  dcza_pkg::in_t               in_data,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output dcza_pkg::out_t              out_data,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [dcza_pkg::CIDX_W-1:0] cfg_index,
	input  logic [dcza_pkg::CFG_W-1:0]  cfg_data
);
	import dcza_pkg::*;

	// configuration registers
	logic [CTR_W-1:0] dcx_q, dcy_q, ccx_q, ccy_q;
	logic [SC_W-1:0]  scx_q, scy_q;
	logic [CW_W-1:0]  cwidth_q, cheight_q;

	// pipeline control and side info
	logic             adv;
	logic             accept;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t            side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t            side_in;

	// axis mapping
	map_cfg_t         mcfg_x, mcfg_y;
	map_res_t         res_x, res_y;

	// store access
	logic [CELL_W-1:0] mem [MEM_DEPTH];
	logic              hit_s4, hit_s5;
	logic [ADDR_W-1:0] addr_s4, addr_s5;
	logic [CELL_W-1:0] rdata_q;
	logic              fwd_q;
	logic [CELL_W-1:0] fwd_data_q;
	logic [CELL_W-1:0] cell_s5;
	logic              wen_s5;
	logic [CELL_W-1:0] wdata_s5;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;

	// clearing sweep
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// output register
	logic              out_valid_q;
	out_t              out_q;

	// ---------------------------------------------------------------
	// configuration writes, unknown indexes are ignored
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcx_q     <= '0;
			dcy_q     <= '0;
			ccx_q     <= '0;
			ccy_q     <= '0;
			scx_q     <= SCALE_RST;
			scy_q     <= SCALE_RST;
			cwidth_q  <= WIDTH_RST;
			cheight_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_DEPTH_CENTER_X: dcx_q     <= cfg_data[CTR_W-1:0];
				REG_DEPTH_CENTER_Y: dcy_q     <= cfg_data[CTR_W-1:0];
				REG_COLOR_CENTER_X: ccx_q     <= cfg_data[CTR_W-1:0];
				REG_COLOR_CENTER_Y: ccy_q     <= cfg_data[CTR_W-1:0];
				REG_SCALE_X:        scx_q     <= cfg_data[SC_W-1:0];
				REG_SCALE_Y:        scy_q     <= cfg_data[SC_W-1:0];
				REG_COLOR_WIDTH:    cwidth_q  <= cfg_data[CW_W-1:0];
				REG_COLOR_HEIGHT:   cheight_q <= cfg_data[CW_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// flow control: everything moves together unless a read result
	// sits at the last stage and the output register cannot take it
	// ---------------------------------------------------------------
	assign adv      = !(out_valid_q && out_stall && v_s5 && side_s5.req == REQ_READ);
	assign in_stall = clr_busy_q || !adv;
	assign accept   = in_valid && !in_stall;

	// request decode at the input
	always_comb begin
		side_in.req      = in_data.req_type;
		side_in.col      = in_data.pix_col;
		side_in.row      = in_data.pix_row;
		side_in.depth    = in_data.depth_mm[CELL_W-1:0];
		side_in.depth_ok = (in_data.depth_mm != '0) && (in_data.depth_mm <= DEPTH_LIMIT);
		side_in.in_store = (32'(in_data.pix_col) < MAX_COLS)
			&& (32'(in_data.pix_row) < MAX_ROWS);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// side info runs alongside the mapping stages
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			hit_s5  <= hit_s4;
			addr_s5 <= addr_s4;
		end
	end

	// ---------------------------------------------------------------
	// remap, one unit per axis; bound is min(color size, store size)
	// ---------------------------------------------------------------
	always_comb begin
		mcfg_x.depth_center = dcx_q;
		mcfg_x.scale        = scx_q;
		mcfg_x.color_center = ccx_q;
		mcfg_x.limit        = (32'(cwidth_q) < MAX_COLS) ? LIM_W'(cwidth_q) : LIM_W'(MAX_COLS);
		mcfg_y.depth_center = dcy_q;
		mcfg_y.scale        = scy_q;
		mcfg_y.color_center = ccy_q;
		mcfg_y.limit        = (32'(cheight_q) < MAX_ROWS) ? LIM_W'(cheight_q) : LIM_W'(MAX_ROWS);
	end

	dcza_axis_map u_map_x (
		.clk (clk),
		.en  (adv),
		.pos (side_s1.col),
		.cfg (mcfg_x),
		.res (res_x)
	);

	dcza_axis_map u_map_y (
		.clk (clk),
		.en  (adv),
		.pos (side_s1.row),
		.cfg (mcfg_y),
		.res (res_y)
	);

	// ---------------------------------------------------------------
	// stage 4: pick the cell and issue the store read
	// ---------------------------------------------------------------
	always_comb begin
		if (side_s4.req == REQ_READ) begin
			hit_s4  = side_s4.in_store;
			addr_s4 = cell_addr(CRD_W'(side_s4.col), CRD_W'(side_s4.row));
		end else begin
			hit_s4  = side_s4.depth_ok && res_x.in_range && res_y.in_range;
			addr_s4 = cell_addr(res_x.coord, res_y.coord);
		end
	end

	// ---------------------------------------------------------------
	// stage 5: compare and write back
	// ---------------------------------------------------------------
	// the store read missed the write made on the same edge, take it from
	// the forward register instead
	assign cell_s5 = fwd_q ? fwd_data_q : rdata_q;
	assign wen_s5  = v_s5 && hit_s5;

	always_comb begin
		if (side_s5.req == REQ_READ) begin
			wdata_s5 = '0;
		end else if (cell_s5 == '0 || side_s5.depth < cell_s5) begin
			wdata_s5 = side_s5.depth;
		end else begin
			wdata_s5 = cell_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (adv) begin
			fwd_q <= wen_s5 && (addr_s4 == addr_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_data_q <= wdata_s5;
		end
	end

	// write port shared with the clearing sweep
	assign mem_we    = clr_busy_q || (adv && wen_s5);
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_s5;
	assign mem_wdata = clr_busy_q ? '0 : wdata_s5;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= mem[addr_s4];
		end
	end

	// clearing sweep after reset, one cell per clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s5 && side_s5.req == REQ_READ) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s5 && side_s5.req == REQ_READ) begin
			out_q.cell_depth <= hit_s5 ? cell_s5 : '0;
			out_q.cell_col   <= side_s5.col;
			out_q.cell_row   <= side_s5.row;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// no request reaches the store while the sweep owns the write port
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s5)
		else $error("request in flight during clearing sweep");

	// the sweep ends only after the last cell
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_addr_q) == ADDR_W'(MEM_DEPTH - 1))
		else $error("clearing sweep ended early");

	// a returned depth is always one that could have been stored
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> 32'(out_q.cell_depth) <= 32'(DEPTH_LIMIT))
		else $error("result depth above limit");

	// a read at the last stage that moves always lands in the output register
	a_read_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s5 && side_s5.req == REQ_READ) |=> out_valid_q)
		else $error("read result lost");

	// a freshly loaded forward flag always follows a write
	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(fwd_q && $past(adv)) |-> $past(mem_we))
		else $error("forward without a store write");

endmodule
